FILE: rtl/core/pidfd_pkg.sv
// Package for the filtered-derivative PID controller.
// Word types, sequencer states, register indexes, widths and saturation helper.
// No dependencies.
package pidfd_pkg;

    localparam int FRAC_BITS = 16;
    localparam int DATA_W    = 32;
    localparam int CFG_IDX_W = 4;
    localparam int MUL_W     = 34;
    localparam int PROD_W    = 2 * MUL_W;
    localparam int SUM_W     = PROD_W + 2;

    localparam logic [CFG_IDX_W-1:0] CFG_KP            = 4'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_KI            = 4'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_KD            = 4'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_HALF_STEP     = 4'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_FILTER_ALPHA  = 4'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_OUT_LIMIT     = 4'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_INTEGRAL_LOW  = 4'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_INTEGRAL_HIGH = 4'd7;

    localparam logic signed [SUM_W-1:0] ONE_Q   = SUM_W'(1) << FRAC_BITS;
    localparam logic signed [SUM_W-1:0] MAX_S32 = SUM_W'(64'sd2147483647);
    localparam logic signed [SUM_W-1:0] MIN_S32 = SUM_W'(-64'sd2147483648);

    typedef struct packed {
        logic signed [DATA_W-1:0] target;
        logic signed [DATA_W-1:0] measured;
        logic                     restart;
    } in_word_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] drive;
        logic                     drive_clamped;
        logic                     integral_clamped;
    } out_word_t;

    typedef enum logic [3:0] {
        SEQ_IDLE,
        SEQ_M1,
        SEQ_M2,
        SEQ_M3,
        SEQ_M4,
        SEQ_M5,
        SEQ_M6,
        SEQ_M7,
        SEQ_FIN
    } seq_state_t;

    function automatic logic signed [DATA_W-1:0] sat32(input logic signed [SUM_W-1:0] x);
        logic signed [DATA_W-1:0] r;
        if (x > MAX_S32) begin
            r = MAX_S32[DATA_W-1:0];
        end else if (x < MIN_S32) begin
            r = MIN_S32[DATA_W-1:0];
        end else begin
            r = x[DATA_W-1:0];
        end
        return r;
    endfunction

endpackage

FILE: rtl/core/pidfd_mul.sv
// Shared signed multiplier with registered product.
// Depends on pidfd_pkg for operand and product widths.
module pidfd_mul (
    input  logic                                 aclk,
    input  logic                                 en,
    input  logic signed [pidfd_pkg::MUL_W-1:0]   a,
    input  logic signed [pidfd_pkg::MUL_W-1:0]   b,
    output logic signed [pidfd_pkg::PROD_W-1:0]  p
);
    import pidfd_pkg::*;

    logic signed [PROD_W-1:0] p_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            p_reg <= a * b;
        end
    end

    assign p = p_reg;

endmodule

FILE: rtl/core/pid_filtered_derivative.sv
// PID controller, trapezoidal integral and filtered derivative, signed Q16.16.
// The sequence forms 7 products on one shared multiplier, then one final sum; a new input
// word is accepted only once the sequence has returned to idle.
// A waiting result does not block the next input word; the final step waits for room.
// Reset (aresetn low, synchronous): loop state zero, registers to defaults, no word held.
// Depends on pidfd_pkg and pidfd_mul.
module pid_filtered_derivative (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  s_valid,
    output logic                                  s_ready,
    input  pidfd_pkg::in_word_t                   s_data,
    output logic                                  m_valid,
    input  logic                                  m_ready,
    output pidfd_pkg::out_word_t                  m_data,
    input  logic                                  cfg_wr_en,
    input  logic [pidfd_pkg::CFG_IDX_W-1:0]       cfg_addr,
    input  logic [pidfd_pkg::DATA_W-1:0]          cfg_wdata
);
    import pidfd_pkg::*;

    seq_state_t seq_state_reg, seq_state_next;

    logic signed [DATA_W-1:0] kp_reg, ki_reg, kd_reg;
    logic        [16:0]       half_step_reg;
    logic        [30:0]       filter_alpha_reg;
    logic        [30:0]       out_limit_reg;
    logic signed [DATA_W-1:0] integral_low_reg, integral_high_reg;

    logic signed [DATA_W-1:0] integral_reg, last_error_reg, last_rate_reg;
    logic signed [DATA_W-1:0] err_reg, clamped_reg, beta_reg, rate_reg;
    logic signed [SUM_W-1:0]  racc_reg, dacc_reg;
    logic                     icl_reg;

    out_word_t out_word_reg;
    logic      m_valid_reg;

    logic                     mul_en;
    logic signed [MUL_W-1:0]  mul_a, mul_b;
    logic signed [PROD_W-1:0] prod;
    logic signed [SUM_W-1:0]  prod_q;
    logic                     out_free;
    logic                     accept;

    logic signed [SUM_W-1:0]  acc_w, lo_w, hi_w, raw_w, lim_w;
    logic signed [DATA_W-1:0] clamped_w, drv_sat, drv_w;
    logic signed [DATA_W:0]   in_diff;

    assign out_free = !m_valid_reg || m_ready;
    assign s_ready  = (seq_state_reg == SEQ_IDLE);
    assign accept   = s_valid && s_ready;
    assign m_valid  = m_valid_reg;
    assign m_data   = out_word_reg;

    pidfd_mul u_mul (
        .aclk (aclk),
        .en   (mul_en),
        .a    (mul_a),
        .b    (mul_b),
        .p    (prod)
    );

    assign prod_q = SUM_W'(prod >>> FRAC_BITS);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seq_state_reg <= SEQ_IDLE;
        end else begin
            seq_state_reg <= seq_state_next;
        end
    end

    always_comb begin
        seq_state_next = seq_state_reg;
        mul_en = 1'b1;
        mul_a  = '0;
        mul_b  = '0;
        case (seq_state_reg)
            SEQ_IDLE: begin
                mul_en = 1'b0;
                if (accept) begin
                    seq_state_next = SEQ_M1;
                end
            end
            SEQ_M1: begin
                mul_a = MUL_W'(err_reg) + MUL_W'(last_error_reg);
                mul_b = MUL_W'($signed({1'b0, half_step_reg}));
                seq_state_next = SEQ_M2;
            end
            SEQ_M2: begin
                mul_a = MUL_W'($signed({1'b0, filter_alpha_reg}));
                mul_b = MUL_W'($signed({1'b0, half_step_reg}));
                seq_state_next = SEQ_M3;
            end
            SEQ_M3: begin
                mul_a = MUL_W'($signed({1'b0, filter_alpha_reg}));
                mul_b = MUL_W'(err_reg) - MUL_W'(last_error_reg);
                seq_state_next = SEQ_M4;
            end
            SEQ_M4: begin
                mul_a = MUL_W'(beta_reg);
                mul_b = MUL_W'(last_rate_reg);
                seq_state_next = SEQ_M5;
            end
            SEQ_M5: begin
                mul_a = MUL_W'(kp_reg);
                mul_b = MUL_W'(err_reg);
                seq_state_next = SEQ_M6;
            end
            SEQ_M6: begin
                mul_a = MUL_W'(ki_reg);
                mul_b = MUL_W'(clamped_reg);
                seq_state_next = SEQ_M7;
            end
            SEQ_M7: begin
                mul_a = MUL_W'(kd_reg);
                mul_b = MUL_W'(rate_reg);
                seq_state_next = SEQ_FIN;
            end
            SEQ_FIN: begin
                mul_en = 1'b0;
                if (out_free) begin
                    seq_state_next = SEQ_IDLE;
                end
            end
            default: begin
                mul_en = 1'b0;
                seq_state_next = SEQ_IDLE;
            end
        endcase
    end

    // error difference, integral clamp, drive saturation and limit
    always_comb begin
        in_diff = (DATA_W+1)'(s_data.target) - (DATA_W+1)'(s_data.measured);
        acc_w = SUM_W'(integral_reg) + prod_q;
        lo_w  = SUM_W'(integral_low_reg);
        hi_w  = SUM_W'(integral_high_reg);
        if (acc_w < lo_w) begin
            clamped_w = integral_low_reg;
        end else if (acc_w < hi_w) begin
            clamped_w = acc_w[DATA_W-1:0];
        end else begin
            clamped_w = integral_high_reg;
        end
        raw_w   = dacc_reg + prod_q;
        drv_sat = sat32(raw_w);
        lim_w   = SUM_W'($signed({1'b0, out_limit_reg}));
        drv_w   = drv_sat;
        if (out_limit_reg != '0) begin
            if (SUM_W'(drv_sat) < -lim_w) begin
                drv_w = -$signed({1'b0, out_limit_reg});
            end else if (SUM_W'(drv_sat) > lim_w) begin
                drv_w = $signed({1'b0, out_limit_reg});
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            integral_reg   <= '0;
            last_error_reg <= '0;
            last_rate_reg  <= '0;
        end else if (accept && s_data.restart) begin
            integral_reg   <= '0;
            last_error_reg <= '0;
            last_rate_reg  <= '0;
        end else if (seq_state_reg == SEQ_FIN && out_free) begin
            integral_reg   <= clamped_reg;
            last_error_reg <= err_reg;
            last_rate_reg  <= rate_reg;
        end
    end

    always_ff @(posedge aclk) begin
        case (seq_state_reg)
            SEQ_IDLE: begin
                err_reg <= sat32(SUM_W'(in_diff));
            end
            SEQ_M2: begin
                clamped_reg <= clamped_w;
                icl_reg     <= (SUM_W'(clamped_w) != acc_w);
            end
            SEQ_M3: begin
                beta_reg <= sat32(ONE_Q - SUM_W'(prod >>> (FRAC_BITS - 1)));
            end
            SEQ_M4: begin
                racc_reg <= prod_q;
            end
            SEQ_M5: begin
                rate_reg <= sat32(racc_reg + prod_q);
            end
            SEQ_M6: begin
                dacc_reg <= prod_q;
            end
            SEQ_M7: begin
                dacc_reg <= dacc_reg + prod_q;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (seq_state_reg == SEQ_FIN && out_free) begin
            out_word_reg.drive            <= drv_w;
            out_word_reg.drive_clamped    <= (SUM_W'(drv_w) != raw_w);
            out_word_reg.integral_clamped <= icl_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (seq_state_reg == SEQ_FIN && out_free) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            kp_reg            <= 32'sd65536;
            ki_reg            <= 32'sd6554;
            kd_reg            <= 32'sd3277;
            half_step_reg     <= 17'd655;
            filter_alpha_reg  <= 31'd1092267;
            out_limit_reg     <= 31'd0;
            integral_low_reg  <= -32'sd6553600;
            integral_high_reg <= 32'sd6553600;
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                CFG_KP:            kp_reg            <= cfg_wdata;
                CFG_KI:            ki_reg            <= cfg_wdata;
                CFG_KD:            kd_reg            <= cfg_wdata;
                CFG_HALF_STEP:     half_step_reg     <= cfg_wdata[16:0];
                CFG_FILTER_ALPHA:  filter_alpha_reg  <= cfg_wdata[30:0];
                CFG_OUT_LIMIT:     out_limit_reg     <= cfg_wdata[30:0];
                CFG_INTEGRAL_LOW:  integral_low_reg  <= cfg_wdata;
                CFG_INTEGRAL_HIGH: integral_high_reg <= cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    a_accept_starts: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> (seq_state_reg == SEQ_M1) && !s_ready)
        else $error("accepted word did not start the sequence");

    a_result_from_fin: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !$past(m_valid)) |-> ($past(seq_state_reg) == SEQ_FIN))
        else $error("result appeared outside the final step");

    a_fin_retires: assert property (@(posedge aclk) disable iff (!aresetn)
        (seq_state_reg == SEQ_FIN && out_free) |=> (seq_state_reg == SEQ_IDLE) && m_valid)
        else $error("final step did not deliver its result");

    a_fin_waits: assert property (@(posedge aclk) disable iff (!aresetn)
        (seq_state_reg == SEQ_FIN && !out_free) |=> (seq_state_reg == SEQ_FIN) && m_valid)
        else $error("final step overran a waiting result");

endmodule
